/* hw/rtl/efem_pkg.sv */
// Types, codes and helpers for the entity fault escalation monitor.
`default_nettype none

package efem_pkg;

  localparam int NUM_ENTITIES = 64;
  localparam int ID_W         = $clog2(NUM_ENTITIES);
  localparam int TALLY_W      = 16;
  localparam int SEQ_W        = 64;
  localparam int TIME_W       = 32;
  localparam int CNT_W        = 7;

  localparam int IN_DATA_W  = 112;
  localparam int OUT_DATA_W = 88;
  localparam int ADDR_W     = 5;

  typedef enum logic [1:0] {
    CMD_SUP = 2'd0,
    CMD_HB  = 2'd1,
    CMD_TMO = 2'd2,
    CMD_CHK = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ACT_NONE    = 2'd0,
    ACT_OBSERVE = 2'd1,
    ACT_ESC1    = 2'd2,
    ACT_ESC2    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    LVL_OK       = 2'd0,
    LVL_WARN     = 2'd1,
    LVL_DEGRADED = 2'd2,
    LVL_FAILED   = 2'd3
  } level_e;

  typedef enum logic [2:0] {
    REG_WINDOW_MS     = 3'd0,
    REG_RESTART_WARN  = 3'd1,
    REG_RESTART_DEGR  = 3'd2,
    REG_RESTART_FAIL  = 3'd3,
    REG_TIMEOUT_DEGR  = 3'd4,
    REG_CHK_SEVERITY  = 3'd5
  } reg_idx_e;

  // supervision kinds that count as a restart
  localparam logic [2:0] SUP_EXITED  = 3'd1;
  localparam logic [2:0] SUP_CASCADE = 3'd2;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [TIME_W-1:0]  window_start;
    logic [TALLY_W-1:0] restart_tally;
    logic [TALLY_W-1:0] timeout_tally;
    logic [1:0]         health_level;
    logic [SEQ_W-1:0]   last_seq;
  } ent_rec_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [ID_W-1:0]   entity_id;
    logic [TIME_W-1:0] now_ms;
    logic [2:0]        sup_kind;
    logic [SEQ_W-1:0]  hb_seq;
    logic              violation;
  } item_t;

  typedef struct packed {
    logic [CNT_W-1:0] degraded_entities;
    logic [CNT_W-1:0] tracked_entities;
    logic [1:0]       worst_level;
    logic [SEQ_W-1:0] missed_beats;
    logic             gap_seen;
    logic [1:0]       action;
  } result_t;

  // saturating tally increment
  function automatic logic [TALLY_W-1:0] bump(input logic [TALLY_W-1:0] v);
    bump = (v == {TALLY_W{1'b1}}) ? v : v + TALLY_W'(1);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/entity_fault_escalation_monitor.sv */
// Top level of the entity fault escalation monitor: record memory, update logic, APB registers.
`default_nettype none

//  Channel  | Dir | Handshake              | Payload
//  ---------+-----+------------------------+-------------------------------------------
//  s_axis   | in  | tvalid/tready          | tuser: cmd; tdata: id, now_ms, kind, seq, viol
//  m_axis   | out | tvalid/tready          | tdata: action, gap, missed, worst, counts
//  apb      | in  | psel/penable/pwrite    | 6 registers at 4*i, pready tied high
//
//  For each word the entity record is first read from the single-port record
//  memory, then updated and written back. The next word is taken once the
//  write has landed, so reads never see stale data.
//  A stalled result holds the update cycle until the output register frees.
//  Reset clears valid bits and histogram and loads register defaults; no clearing pass.

module entity_fault_escalation_monitor
  import efem_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // stream in
  input  wire logic                  s_axis_tvalid_i,
  output logic                       s_axis_tready_o,
  // low to high: entity_id[5:0], now_ms[37:6], sup_kind[40:38], hb_seq[104:41],
  // violation[105], zero pad[111:106]
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  // cmd[1:0]
  input  wire logic [1:0]            s_axis_tuser_i,
  // stream out
  output logic                       m_axis_tvalid_o,
  input  wire logic                  m_axis_tready_i,
  // low to high: action[1:0], gap_seen[2], missed_beats[66:3], worst_level[68:67],
  // tracked_entities[75:69], degraded_entities[82:76], zero pad[87:83]
  output logic [OUT_DATA_W-1:0]      m_axis_tdata_o,
  // APB register port
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [ADDR_W-1:0]     paddr,
  input  wire logic [31:0]           pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  // ---------------------------------------------------------------- registers
  logic [TIME_W-1:0]  win_ms_q;
  logic [TALLY_W-1:0] rst_warn_q, rst_degr_q, rst_fail_q, tmo_degr_q;
  logic [1:0]         chk_sev_q;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  assign pready  = 1'b1;
  assign cfg_idx = paddr[ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_ms_q   <= TIME_W'(30000);
      rst_warn_q <= TALLY_W'(1);
      rst_degr_q <= TALLY_W'(3);
      rst_fail_q <= TALLY_W'(5);
      tmo_degr_q <= TALLY_W'(5);
      chk_sev_q  <= 2'd2;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_WINDOW_MS:    win_ms_q   <= pwdata;
        REG_RESTART_WARN: rst_warn_q <= pwdata[TALLY_W-1:0];
        REG_RESTART_DEGR: rst_degr_q <= pwdata[TALLY_W-1:0];
        REG_RESTART_FAIL: rst_fail_q <= pwdata[TALLY_W-1:0];
        REG_TIMEOUT_DEGR: tmo_degr_q <= pwdata[TALLY_W-1:0];
        REG_CHK_SEVERITY: chk_sev_q  <= pwdata[1:0];
        default: ;  // unlisted index: ignored
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WINDOW_MS:    prdata = win_ms_q;
      REG_RESTART_WARN: prdata = {16'd0, rst_warn_q};
      REG_RESTART_DEGR: prdata = {16'd0, rst_degr_q};
      REG_RESTART_FAIL: prdata = {16'd0, rst_fail_q};
      REG_TIMEOUT_DEGR: prdata = {16'd0, tmo_degr_q};
      REG_CHK_SEVERITY: prdata = {30'd0, chk_sev_q};
      default:          prdata = 32'd0;
    endcase
  end

  // ---------------------------------------------------------------- control
  state_e  state_q, state_d;
  logic    s_fire, exec_fire;
  logic    m_valid_q, m_valid_d;

  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  always_comb begin
    state_d         = state_q;
    s_axis_tready_o = 1'b0;
    exec_fire       = 1'b0;
    case (state_q)
      ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        // wait for the output register to drain
        if (!m_valid_q || m_axis_tready_i) begin
          exec_fire = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- item capture
  item_t item_q;

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      item_q.cmd       <= s_axis_tuser_i;
      item_q.entity_id <= s_axis_tdata_i[ID_W-1:0];
      item_q.now_ms    <= s_axis_tdata_i[37:6];
      item_q.sup_kind  <= s_axis_tdata_i[40:38];
      item_q.hb_seq    <= s_axis_tdata_i[104:41];
      item_q.violation <= s_axis_tdata_i[105];
    end
  end

  // ---------------------------------------------------------------- record memory
  ent_rec_t rec_mem [NUM_ENTITIES];
  ent_rec_t rd_q, rec_d;
  logic     wr_en;

  always_ff @(posedge clk_i) begin
    if (s_fire) rd_q <= rec_mem[s_axis_tdata_i[ID_W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) rec_mem[item_q.entity_id] <= rec_d;
  end

  // per-entity valid bits; a record field is only trusted behind its bit
  logic [NUM_ENTITIES-1:0] tracked_q, win_open_q, seq_seen_q;
  logic [CNT_W-1:0]        hist_q [4];
  logic [CNT_W-1:0]        hist_d [4];

  // ---------------------------------------------------------------- update logic
  logic               ent_ok, tr, wo, ss, expire;
  logic [1:0]         lvl_old, lvl_new;
  logic [TALLY_W-1:0] rt_base, to_base, rt_inc, to_inc;
  logic [TIME_W-1:0]  age;
  logic [SEQ_W-1:0]   seq_next;
  logic               gap_hit;
  logic               do_touch, do_age, do_seq, set_lvl;
  result_t            res;
  logic [CNT_W-1:0]   tot_cnt;

  assign ent_ok   = (32'(item_q.entity_id) < NUM_ENTITIES);
  assign tr       = tracked_q[item_q.entity_id];
  assign wo       = win_open_q[item_q.entity_id];
  assign ss       = seq_seen_q[item_q.entity_id];
  assign lvl_old  = tr ? rd_q.health_level : LVL_OK;
  assign age      = item_q.now_ms - rd_q.window_start;
  assign expire   = !wo || ((win_ms_q != '0) && (age > win_ms_q));
  assign rt_base  = expire ? '0 : rd_q.restart_tally;
  assign to_base  = expire ? '0 : rd_q.timeout_tally;
  assign rt_inc   = bump(rt_base);
  assign to_inc   = bump(to_base);
  assign seq_next = rd_q.last_seq + SEQ_W'(1);
  // no gap after the all-ones number
  assign gap_hit  = ss && (rd_q.last_seq != {SEQ_W{1'b1}}) && (item_q.hb_seq > seq_next);

  always_comb begin
    rec_d    = rd_q;
    do_touch = 1'b0;
    do_age   = 1'b0;
    do_seq   = 1'b0;
    set_lvl  = 1'b0;
    lvl_new  = lvl_old;
    res      = '0;
    res.action = ACT_NONE;

    if (ent_ok) begin
      case (item_q.cmd)
        CMD_SUP: begin
          if (item_q.sup_kind inside {SUP_EXITED, SUP_CASCADE}) begin
            do_age = 1'b1;
            if (rt_inc >= rst_fail_q) begin
              set_lvl    = 1'b1;
              lvl_new    = LVL_FAILED;
              res.action = ACT_ESC2;
            end else if (rt_inc >= rst_degr_q) begin
              set_lvl    = 1'b1;
              lvl_new    = LVL_DEGRADED;
              res.action = ACT_ESC1;
            end else if (rt_inc >= rst_warn_q) begin
              if (lvl_old == LVL_OK) begin
                set_lvl = 1'b1;
                lvl_new = LVL_WARN;
              end
              res.action = ACT_OBSERVE;
            end
          end
        end
        CMD_HB: begin
          do_touch = 1'b1;
          do_seq   = 1'b1;
          if (gap_hit) begin
            res.gap_seen     = 1'b1;
            res.missed_beats = item_q.hb_seq - seq_next;
          end
        end
        CMD_TMO: begin
          do_age = 1'b1;
          if (to_inc >= tmo_degr_q) begin
            set_lvl    = 1'b1;
            lvl_new    = LVL_DEGRADED;
            res.action = ACT_ESC1;
          end else begin
            if (lvl_old == LVL_OK) begin
              set_lvl = 1'b1;
              lvl_new = LVL_WARN;
            end
            res.action = ACT_OBSERVE;
          end
        end
        CMD_CHK: begin
          if (item_q.violation) begin
            do_age     = 1'b1;
            set_lvl    = 1'b1;
            lvl_new    = (chk_sev_q >= 2'd2) ? LVL_DEGRADED : LVL_WARN;
            res.action = ACT_ESC1;
          end
        end
        default: ;
      endcase
    end

    if (do_age) begin
      do_touch            = 1'b1;
      rec_d.window_start  = expire ? item_q.now_ms : rd_q.window_start;
      rec_d.restart_tally = rt_base;
      rec_d.timeout_tally = to_base;
      if (item_q.cmd == CMD_SUP) rec_d.restart_tally = rt_inc;
      if (item_q.cmd == CMD_TMO) rec_d.timeout_tally = to_inc;
    end
    if (do_seq) rec_d.last_seq = item_q.hb_seq;
    rec_d.health_level = set_lvl ? lvl_new : lvl_old;

    // histogram: a new entity enters at ok, then moves with its level
    hist_d = hist_q;
    if (do_touch && !tr) hist_d[LVL_OK] = hist_d[LVL_OK] + CNT_W'(1);
    if (set_lvl) begin
      hist_d[lvl_old] = hist_d[lvl_old] - CNT_W'(1);
      hist_d[lvl_new] = hist_d[lvl_new] + CNT_W'(1);
    end

    if      (hist_d[LVL_FAILED]   != '0) res.worst_level = LVL_FAILED;
    else if (hist_d[LVL_DEGRADED] != '0) res.worst_level = LVL_DEGRADED;
    else if (hist_d[LVL_WARN]     != '0) res.worst_level = LVL_WARN;
    else                                 res.worst_level = LVL_OK;
    res.tracked_entities  = hist_d[0] + hist_d[1] + hist_d[2] + hist_d[3];
    res.degraded_entities = hist_d[LVL_DEGRADED] + hist_d[LVL_FAILED];
  end

  assign wr_en   = exec_fire && do_touch;
  assign tot_cnt = hist_q[0] + hist_q[1] + hist_q[2] + hist_q[3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tracked_q  <= '0;
      win_open_q <= '0;
      seq_seen_q <= '0;
      for (int i = 0; i < 4; i++) hist_q[i] <= '0;
    end else if (exec_fire) begin
      if (do_touch) tracked_q[item_q.entity_id]  <= 1'b1;
      if (do_age)   win_open_q[item_q.entity_id] <= 1'b1;
      if (do_seq)   seq_seen_q[item_q.entity_id] <= 1'b1;
      hist_q <= hist_d;
    end
  end

  // ---------------------------------------------------------------- output register
  result_t out_q;

  assign m_valid_d = exec_fire ? 1'b1 : (m_axis_tready_i ? 1'b0 : m_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) m_valid_q <= 1'b0;
    else         m_valid_q <= m_valid_d;
  end

  always_ff @(posedge clk_i) begin
    if (exec_fire) out_q <= res;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {5'd0, out_q};

  // ---------------------------------------------------------------- assertions
  // one word in flight: no accept right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready_o)
    else $error("word accepted while another is in the update stage");

  // finishing the update stage always presents a result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec_fire |=> m_axis_tvalid_o)
    else $error("update finished without a result");

  // histogram population equals number of tracked entities
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'($countones(tracked_q)) == tot_cnt)
    else $error("level histogram out of step with tracked entities");

  // degraded count never exceeds tracked count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hist_q[LVL_DEGRADED] + hist_q[LVL_FAILED]) <= tot_cnt)
    else $error("degraded count exceeds tracked count");

endmodule

`default_nettype wire
